/* src/bole_pkg.sv */
// Shared types and constants for the bounded ordered list engine.
// Used by the channel interfaces, the top level, the checker and the testbench.
// No dependencies.
package bole_pkg;

  // Storage geometry.
  localparam int MAX_ENTRIES = 16;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  // Fixed field widths of the channels and the register.
  localparam int FUNC_W   = 3;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 4;
  localparam int ENTRY_W  = 5;
  localparam int CAP_W    = 5;

  // Width that holds both the capacity register and the entry count.
  localparam int CAPX_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // Capacity register value after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Operation codes on the func field.
  localparam logic [FUNC_W-1:0] FN_INSERT_HEAD = 3'd0;
  localparam logic [FUNC_W-1:0] FN_APPEND_TAIL = 3'd1;
  localparam logic [FUNC_W-1:0] FN_REMOVE      = 3'd2;
  localparam logic [FUNC_W-1:0] FN_FIND        = 3'd3;
  localparam logic [FUNC_W-1:0] FN_CLEAR       = 3'd4;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHUP,
    S_HEAD,
    S_SHDN,
    S_DONE
  } state_t;

endpackage

/* src/bole_if.sv */
// Valid/ready channel interfaces for the list engine command and result beats.
// Depends on bole_pkg for the field widths.
interface bole_in_if import bole_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface bole_out_if import bole_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [POS_W-1:0]     position;
  logic [ENTRY_W-1:0]   entry_count;
  logic                 list_empty;
  logic                 list_full;

  modport source (output valid, output status, output position, output entry_count,
                  output list_empty, output list_full, input ready);
  modport sink   (input valid, input status, input position, input entry_count,
                  input list_empty, input list_full, output ready);
endinterface

/* src/bole_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bole_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/bounded_ordered_list_engine_unit.sv */
// Top level of the bounded ordered list engine: sequencer, counters and result register.
// Depends on bole_pkg, the bole_in_if / bole_out_if interfaces and bole_ram.
//
//   channel   | dir | handshake      | payload
//   ----------+-----+----------------+----------------------------------------------
//   in_bus    | in  | valid / ready  | func[2:0], value[31:0] signed
//   out_bus   | out | valid / ready  | status[1:0], position[3:0], entry_count[4:0],
//             |     |                | list_empty, list_full
//   cfg       | in  | cfg_we         | cfg_wdata[4:0] = capacity_limit
//
// Append, clear, refused and unused operations go straight to the finish state after
// accept, and insert at head on an empty list passes through the head state first.
// Otherwise insert at head, find and remove walk the list through the single read and
// single write port of the entry RAM, one entry per cycle.
// Reset is synchronous and active low; no clearing pass is needed, as only entries
// below the count are read. A stalled result beat holds in the output register while
// the next command beat is accepted; the engine waits in its finish state if needed.
module bounded_ordered_list_engine_unit import bole_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  bole_in_if.sink            in_bus,
  bole_out_if.source         out_bus,
  input  logic               cfg_we,
  input  logic [CAP_W-1:0]   cfg_wdata
);

  // Control state.
  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    occ_r, occ_nxt;
  logic [CAP_W-1:0]    cap_r, cap_nxt;
  logic                issue_r, issue_nxt;
  logic                pend_r, pend_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Command and walk payload.
  logic [FUNC_W-1:0]   func_r, func_nxt;
  logic [DATA_W-1:0]   val_r, val_nxt;
  logic [ADDR_W-1:0]   ptr_r, ptr_nxt;
  logic [ADDR_W-1:0]   tag_r, tag_nxt;
  status_t             st_r, st_nxt;
  logic [ADDR_W-1:0]   pos_r, pos_nxt;

  // Result register.
  status_t             out_status_r, out_status_nxt;
  logic [POS_W-1:0]    out_pos_r, out_pos_nxt;
  logic [ENTRY_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic                out_empty_r, out_empty_nxt;
  logic                out_full_r, out_full_nxt;

  // Entry RAM port.
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [DATA_W-1:0]   ram_wdata;
  logic [DATA_W-1:0]   ram_rdata;

  // Derived values.
  logic                in_acc;
  logic                out_free;
  logic [CAPX_W-1:0]   cap_x;
  logic [CAPX_W-1:0]   eff_cap;
  logic                is_full;
  logic [CNT_W-1:0]    occ_inc;
  logic [CNT_W-1:0]    occ_dec;
  logic [ADDR_W-1:0]   last_idx;
  logic [ADDR_W-1:0]   ptr_inc;
  logic [ADDR_W-1:0]   ptr_dec;
  logic                hit;
  logic                tag_last;

  bole_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ptr_r),
    .rdata (ram_rdata)
  );

  // Handshakes.
  assign in_acc        = in_bus.valid && in_bus.ready;
  assign in_bus.ready  = (state_r == S_IDLE);
  assign out_free      = !out_valid_r || out_bus.ready;

  // Effective capacity clamps zero up to one and large values down to the store size.
  assign cap_x   = CAPX_W'(cap_r);
  assign eff_cap = (cap_x == '0) ? CAPX_W'(1) :
                   (cap_x > CAPX_W'(MAX_ENTRIES)) ? CAPX_W'(MAX_ENTRIES) : cap_x;
  assign is_full = CAPX_W'(occ_r) >= eff_cap;

  // Shared step unit for the count and the walk pointer.
  assign occ_inc  = occ_r + CNT_W'(1);
  assign occ_dec  = occ_r - CNT_W'(1);
  assign last_idx = occ_dec[ADDR_W-1:0];
  assign ptr_inc  = ptr_r + ADDR_W'(1);
  assign ptr_dec  = ptr_r - ADDR_W'(1);

  // Shared comparator on the entry just read.
  assign hit      = pend_r && (ram_rdata == val_r);
  assign tag_last = (tag_r == last_idx);

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_bus.func) inside
            FN_INSERT_HEAD: begin
              if (is_full) begin
                state_nxt = S_DONE;
              end else if (occ_r == '0) begin
                state_nxt = S_HEAD;
              end else begin
                state_nxt = S_SHUP;
              end
            end
            FN_REMOVE, FN_FIND: begin
              state_nxt = (occ_r == '0) ? S_DONE : S_SCAN;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_nxt = ((func_r == FN_REMOVE) && !tag_last) ? S_SHDN : S_DONE;
        end else if (pend_r && tag_last) begin
          state_nxt = S_DONE;
        end
      end
      S_SHUP: begin
        if (!issue_r && pend_r) begin
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        state_nxt = S_DONE;
      end
      S_SHDN: begin
        if (!issue_r && pend_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Datapath, RAM controls and result register loads.
  always_comb begin
    occ_nxt        = occ_r;
    cap_nxt        = cfg_we ? cfg_wdata : cap_r;
    issue_nxt      = issue_r;
    pend_nxt       = pend_r;
    func_nxt       = func_r;
    val_nxt        = val_r;
    ptr_nxt        = ptr_r;
    tag_nxt        = tag_r;
    st_nxt         = st_r;
    pos_nxt        = pos_r;
    ram_we         = 1'b0;
    ram_waddr      = tag_r;
    ram_wdata      = ram_rdata;
    out_valid_nxt  = out_valid_r && !out_bus.ready;
    out_status_nxt = out_status_r;
    out_pos_nxt    = out_pos_r;
    out_cnt_nxt    = out_cnt_r;
    out_empty_nxt  = out_empty_r;
    out_full_nxt   = out_full_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          func_nxt  = in_bus.func;
          val_nxt   = in_bus.value;
          st_nxt    = ST_OK;
          pos_nxt   = '0;
          issue_nxt = 1'b1;
          pend_nxt  = 1'b0;
          unique case (in_bus.func) inside
            FN_INSERT_HEAD: begin
              if (is_full) begin
                st_nxt = ST_FULL;
              end else begin
                ptr_nxt = last_idx;
              end
            end
            FN_APPEND_TAIL: begin
              if (is_full) begin
                st_nxt = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = occ_r[ADDR_W-1:0];
                ram_wdata = in_bus.value;
                occ_nxt   = occ_inc;
              end
            end
            FN_REMOVE, FN_FIND: begin
              if (occ_r == '0) begin
                st_nxt = ST_EMPTY;
              end else begin
                ptr_nxt = '0;
              end
            end
            FN_CLEAR: begin
              occ_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      // Walk from the head, comparing each entry in the cycle after its read.
      S_SCAN: begin
        if (hit) begin
          pos_nxt = tag_r;
          if (func_r == FN_REMOVE) begin
            if (tag_last) begin
              occ_nxt = occ_dec;
            end else begin
              // The pointer already sits on the entry after the match.
              issue_nxt = 1'b1;
              pend_nxt  = 1'b0;
            end
          end
        end else if (pend_r && tag_last) begin
          st_nxt = ST_NOTFOUND;
        end else if (issue_r) begin
          pend_nxt = 1'b1;
          tag_nxt  = ptr_r;
          if (ptr_r == last_idx) begin
            issue_nxt = 1'b0;
          end else begin
            ptr_nxt = ptr_inc;
          end
        end else begin
          pend_nxt = 1'b0;
        end
      end

      // Move entries one place toward the tail, starting from the tail.
      S_SHUP: begin
        if (pend_r) begin
          ram_we = 1'b1;
        end
        if (issue_r) begin
          pend_nxt = 1'b1;
          tag_nxt  = ptr_inc;
          if (ptr_r == '0) begin
            issue_nxt = 1'b0;
          end else begin
            ptr_nxt = ptr_dec;
          end
        end else begin
          pend_nxt = 1'b0;
        end
      end

      // Place the new head entry.
      S_HEAD: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = val_r;
        occ_nxt   = occ_inc;
      end

      // Close the gap left by the removed entry.
      S_SHDN: begin
        if (pend_r) begin
          ram_we = 1'b1;
          if (!issue_r) begin
            occ_nxt = occ_dec;
          end
        end
        if (issue_r) begin
          pend_nxt = 1'b1;
          tag_nxt  = ptr_dec;
          if (ptr_r == last_idx) begin
            issue_nxt = 1'b0;
          end else begin
            ptr_nxt = ptr_inc;
          end
        end else begin
          pend_nxt = 1'b0;
        end
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = st_r;
          out_pos_nxt    = POS_W'(pos_r);
          out_cnt_nxt    = ENTRY_W'(occ_r);
          out_empty_nxt  = (occ_r == '0);
          out_full_nxt   = is_full;
        end
      end

      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      cap_r       <= CAP_RESET;
      issue_r     <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      cap_r       <= cap_nxt;
      issue_r     <= issue_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    val_r        <= val_nxt;
    ptr_r        <= ptr_nxt;
    tag_r        <= tag_nxt;
    st_r         <= st_nxt;
    pos_r        <= pos_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_empty_r  <= out_empty_nxt;
    out_full_r   <= out_full_nxt;
  end

  // Result channel.
  assign out_bus.valid       = out_valid_r;
  assign out_bus.status      = out_status_r;
  assign out_bus.position    = out_pos_r;
  assign out_bus.entry_count = out_cnt_r;
  assign out_bus.list_empty  = out_empty_r;
  assign out_bus.list_full   = out_full_r;

  // The count never exceeds the store size.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(MAX_ENTRIES))
    else $error("entry count exceeds store size");

  // After a command beat is taken, no other is taken in the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_bus.valid && in_bus.ready |=> !in_bus.ready)
    else $error("command beat accepted while busy");

  // Writes never land beyond the slot just past the tail.
  a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (CNT_W'(ram_waddr) <= occ_r))
    else $error("store write beyond tail");

  // The count moves by at most one per cycle, except when cleared.
  a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (occ_r == $past(occ_r)) || (occ_r == $past(occ_r) + 1'b1) ||
                     (occ_r == $past(occ_r) - 1'b1) || (occ_r == '0))
    else $error("entry count jumped");

endmodule

/* sim/bole_list_checker.sv */
// Checker for the bounded ordered list engine: watches the command, result and register ports.
// Keeps its own copy of the list, predicts each result beat and compares it field by field.
// Depends on bole_pkg and the bole_in_if / bole_out_if interfaces.
module bole_list_checker import bole_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  bole_in_if                    cmd_mon,
  bole_out_if                   rsp_mon,
  input  logic                  cfg_we,
  input  logic [CAP_W-1:0]      cfg_wdata,
  output int                    fail_count,
  output int                    pending,
  output int                    checked
);

  typedef struct packed {
    status_t            status;
    logic [POS_W-1:0]   position;
    logic [ENTRY_W-1:0] entry_count;
    logic               list_empty;
    logic               list_full;
  } list_result_t;

  // Shadow copy of the list and the capacity register.
  logic [DATA_W-1:0] shadow_list [MAX_ENTRIES];
  int                shadow_count;
  logic [CAP_W-1:0]  shadow_cap;

  list_result_t      expected_q [$];
  int                fails;
  int                compared;

  // A zero capacity acts as one, and anything above the store size acts as the store size.
  function automatic int capacity_in_force();
    if (shadow_cap == '0) return 1;
    if (shadow_cap > MAX_ENTRIES) return MAX_ENTRIES;
    return int'(shadow_cap);
  endfunction

  // Applies one command to the shadow list and returns the result it must produce.
  function automatic list_result_t apply_cmd(input logic [FUNC_W-1:0] op,
                                             input logic [DATA_W-1:0] val);
    list_result_t res;
    int           hit;
    res.status   = ST_OK;
    res.position = '0;
    case (op) inside
      FN_INSERT_HEAD, FN_APPEND_TAIL: begin
        if (shadow_count >= capacity_in_force()) begin
          res.status = ST_FULL;
        end else if (op == FN_INSERT_HEAD) begin
          for (int i = shadow_count; i > 0; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[0] = val;
          shadow_count++;
        end else begin
          shadow_list[shadow_count] = val;
          shadow_count++;
        end
      end
      FN_REMOVE, FN_FIND: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          hit = -1;
          for (int i = 0; i < shadow_count; i++) begin
            if (hit < 0 && shadow_list[i] == val) hit = i;
          end
          if (hit < 0) begin
            res.status = ST_NOTFOUND;
          end else begin
            res.position = hit[POS_W-1:0];
            if (op == FN_REMOVE) begin
              // Close the gap so the remaining entries keep their order.
              for (int i = hit; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
              shadow_count--;
            end
          end
        end
      end
      FN_CLEAR: begin
        shadow_count = 0;
      end
      default: begin
      end
    endcase
    res.entry_count = shadow_count[ENTRY_W-1:0];
    res.list_empty  = (shadow_count == 0);
    res.list_full   = (shadow_count >= capacity_in_force());
    return res;
  endfunction

  // Result beats are checked before the command beat of the same edge is predicted,
  // since a result always trails its command.
  always @(posedge clk) begin
    list_result_t want;
    list_result_t got;
    if (!rst_n) begin
      shadow_count = 0;
      shadow_cap   = CAP_RESET;
      expected_q.delete();
      fails        = 0;
      compared     = 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        got.status      = status_t'(rsp_mon.status);
        got.position    = rsp_mon.position;
        got.entry_count = rsp_mon.entry_count;
        got.list_empty  = rsp_mon.list_empty;
        got.list_full   = rsp_mon.list_full;
        if (expected_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("[%0t] result beat with nothing pending: status=%0d pos=%0d count=%0d",
                     $realtime, got.status, got.position, got.entry_count);
        end else begin
          want = expected_q.pop_front();
          compared++;
          if (got.status !== want.status || got.position !== want.position ||
              got.entry_count !== want.entry_count || got.list_empty !== want.list_empty ||
              got.list_full !== want.list_full) begin
            fails++;
            if (fails <= 10) begin
              $display("[%0t] result mismatch on beat %0d", $realtime, compared);
              $display("  expected status=%0d pos=%0d count=%0d empty=%0b full=%0b",
                       want.status, want.position, want.entry_count, want.list_empty,
                       want.list_full);
              $display("  actual   status=%0d pos=%0d count=%0d empty=%0b full=%0b",
                       got.status, got.position, got.entry_count, got.list_empty,
                       got.list_full);
            end
          end
        end
      end
      if (cmd_mon.valid && cmd_mon.ready)
        expected_q.push_back(apply_cmd(cmd_mon.func, cmd_mon.value));
      if (cfg_we)
        shadow_cap = cfg_wdata;
    end
    fail_count <= fails;
    pending    <= expected_q.size();
    checked    <= compared;
  end

endmodule

/* sim/tb_bounded_ordered_list_engine_unit.sv */
// Testbench top for the bounded ordered list engine: clock, reset, command and register stimulus.
// Depends on bole_pkg, the channel interfaces, the engine and bole_list_checker.
module tb_bounded_ordered_list_engine_unit;
  import bole_pkg::*;

  // Operation codes the engine must treat as no-ops.
  localparam logic [FUNC_W-1:0] FN_SPARE_A = 3'd5;
  localparam logic [FUNC_W-1:0] FN_SPARE_B = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_C = 3'd7;

  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int POOL_SIZE       = 6;
  localparam int QUIET_PHASE     = 3;
  localparam logic [CAP_W-1:0] PHASE_CAPS [NUM_PHASES] =
    '{5'd16, 5'd31, 5'd1, 5'd5, 5'd0, 5'd12, 5'd3, 5'd16};

  localparam logic [DATA_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [DATA_W-1:0] VAL_MAX = 32'h7fff_ffff;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  int fail_count;
  int pending;
  int checked;
  int cmds_sent;
  int cap_writes;
  bit idle_on;
  bit stall_on;
  logic [DATA_W-1:0] value_pool [POOL_SIZE];

  bole_in_if  in_bus ();
  bole_out_if out_bus ();

  bounded_ordered_list_engine_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  bole_list_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_mon    (in_bus),
    .rsp_mon    (out_bus),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result side: drop ready now and then while stalls are enabled.
  always @(posedge clk) begin
    if (!rst_n)
      out_bus.ready <= 1'b0;
    else
      out_bus.ready <= !(stall_on && $urandom_range(0, 99) < 8);
  end

  // Sends one command beat, idling first at random, and returns once it is accepted.
  task automatic send_cmd(input logic [FUNC_W-1:0] op, input logic [DATA_W-1:0] val);
    while (idle_on && $urandom_range(0, 99) < 8) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.func  <= op;
    in_bus.value <= val;
    do @(posedge clk); while (!in_bus.ready);
    cmds_sent++;
  endtask

  // Holds the command side quiet until every predicted result has come back.
  task automatic wait_for_results();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Register write; only called while the engine is idle.
  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    cfg_wdata <= cap;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cap_writes++;
  endtask

  // Picks an operation; grow_pct weights inserts and appends against removes and finds.
  function automatic logic [FUNC_W-1:0] pick_func(input int grow_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) begin
      case ($urandom_range(0, 2))
        0:       return FN_SPARE_A;
        1:       return FN_SPARE_B;
        default: return FN_SPARE_C;
      endcase
    end
    if (r < 5) return FN_CLEAR;
    if ($urandom_range(0, 99) < grow_pct)
      return $urandom_range(0, 1) ? FN_APPEND_TAIL : FN_INSERT_HEAD;
    return $urandom_range(0, 1) ? FN_FIND : FN_REMOVE;
  endfunction

  // Mostly values from a small pool so that removes and finds hit, with duplicates.
  function automatic logic [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (r < 90) return $urandom;
    case ($urandom_range(0, 3))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  initial begin
    rst_n         <= 1'b0;
    in_bus.valid  <= 1'b0;
    in_bus.func   <= FN_INSERT_HEAD;
    in_bus.value  <= '0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    cmds_sent     = 0;
    cap_writes    = 0;
    idle_on       = 1'b1;
    stall_on      = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty list, extremes, duplicates, absent values and the spare codes.
    send_cmd(FN_REMOVE, 32'd5);
    send_cmd(FN_FIND, 32'd5);
    send_cmd(FN_INSERT_HEAD, VAL_MIN);
    send_cmd(FN_APPEND_TAIL, VAL_MAX);
    send_cmd(FN_INSERT_HEAD, '0);
    send_cmd(FN_APPEND_TAIL, '1);
    send_cmd(FN_FIND, VAL_MAX);
    send_cmd(FN_FIND, 32'd12345);
    send_cmd(FN_REMOVE, VAL_MIN);
    send_cmd(FN_REMOVE, 32'd777);
    send_cmd(FN_INSERT_HEAD, VAL_MAX);
    send_cmd(FN_FIND, VAL_MAX);
    send_cmd(FN_SPARE_A, 32'd1);
    send_cmd(FN_SPARE_B, 32'd2);
    send_cmd(FN_SPARE_C, 32'd3);

    // Capacity lowered below the current count: inserts are refused, nothing is dropped.
    wait_for_results();
    set_capacity(5'd2);
    send_cmd(FN_APPEND_TAIL, 32'd9);
    send_cmd(FN_INSERT_HEAD, 32'd9);
    send_cmd(FN_REMOVE, '0);
    send_cmd(FN_CLEAR, '0);

    // A zero capacity acts as a single entry.
    wait_for_results();
    set_capacity(5'd0);
    send_cmd(FN_APPEND_TAIL, 32'd42);
    send_cmd(FN_INSERT_HEAD, 32'd43);
    send_cmd(FN_FIND, 32'd42);
    send_cmd(FN_REMOVE, 32'd42);

    // Random phases: each fills the list in its first half and drains it in the second.
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_for_results();
      set_capacity(PHASE_CAPS[p]);
      idle_on  = (p != QUIET_PHASE);
      stall_on = (p != QUIET_PHASE);
      for (int k = 0; k < POOL_SIZE; k++) value_pool[k] = $urandom;
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        send_cmd(pick_func((n < ITEMS_PER_PHASE / 2) ? 70 : 30), pick_value());
    end

    wait_for_results();
    repeat (50) @(posedge clk);
    $display("Sent %0d commands over %0d capacity writes; %0d result beats compared.",
             cmds_sent, cap_writes, checked);
    $display("Capacities 0, 1, 2, 3, 5, 12, 16 and 31 were used, with and without stalls.");
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #30000000;
    $display("Timeout with %0d results still pending.", pending);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
